FILE: src/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
    else $error("same-cycle implication failed");

// Next-cycle implication, checked outside reset.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
    else $error("next-cycle implication failed");

`endif

FILE: src/crp_pkg.sv
`timescale 1ns / 1ps

package crp_pkg;

  localparam int TIMEOUT_W = 20;
  localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = 20'd1000;
  localparam int TMO3_W = TIMEOUT_W + 2;
  localparam logic [TMO3_W-1:0] TMO3_RESET = TMO3_W'(3 * 1000);

  // fixed line positions
  localparam int POS_THIRD = 2;
  localparam int POS_INFO_LAST = 9;
  localparam int POS_TX = 26;
  localparam int TX_MIN_LEN = 27;

  localparam logic CMD_BYTE = 1'b0;
  localparam logic CMD_TICK = 1'b1;

  localparam logic [7:0] CH_SEMI  = 8'h3B;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_ONE   = 8'h31;
  localparam logic [7:0] CH_TWO   = 8'h32;

  localparam logic [15:0] LN_FA = 16'h4641;
  localparam logic [15:0] LN_FB = 16'h4642;
  localparam logic [15:0] LN_MD = 16'h4D44;
  localparam logic [15:0] LN_TX = 16'h5458;
  localparam logic [15:0] LN_SM = 16'h534D;
  localparam logic [15:0] LN_PC = 16'h5043;
  localparam logic [15:0] LN_PO = 16'h504F;
  localparam logic [15:0] LN_IF = 16'h4946;
  localparam logic [15:0] LN_OM = 16'h4F4D;

  localparam logic [7:0] MODE_INVALID = 8'hFF;

  typedef enum logic [3:0] {
    KIND_NONE  = 4'd0,
    KIND_OTHER = 4'd1,
    KIND_FA    = 4'd2,
    KIND_FB    = 4'd3,
    KIND_MD    = 4'd4,
    KIND_TX    = 4'd5,
    KIND_SM    = 4'd6,
    KIND_PC    = 4'd7,
    KIND_PO    = 4'd8,
    KIND_IF    = 4'd9,
    KIND_OM    = 4'd10
  } kind_t;

  typedef enum logic [1:0] {
    OP_BYTE   = 2'd0,
    OP_TICK   = 2'd1,
    OP_FINISH = 2'd2
  } op_t;

  // Item handed from the line stage to the status stage.
  typedef struct packed {
    op_t         op;
    logic [7:0]  first;
    logic [7:0]  second;
    logic        has_two;
    logic        has_third;
    logic        has_tx_letter;
    logic [31:0] digit_value;
    logic        over16;
    logic [26:0] info_freq;
  } tok_t;

  function automatic logic [7:0] map_mode(input logic [7:0] c);
    logic [7:0] m;
    case (c)
      8'h30:   m = 8'h00;
      8'h31:   m = 8'h01;
      8'h32:   m = 8'h03;
      8'h33:   m = 8'h05;
      8'h34:   m = 8'h02;
      8'h35:   m = 8'h04;
      8'h36:   m = 8'h07;
      8'h37:   m = 8'h08;
      default: m = MODE_INVALID;
    endcase
    return m;
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= CH_ZERO) && (c <= CH_NINE);
  endfunction

endpackage

FILE: src/crp_if.sv
`timescale 1ns / 1ps

interface crp_in_if;
  logic       valid;
  logic       ready;
  logic       command;
  logic [7:0] rx_byte;
  modport source(output valid, command, rx_byte, input ready);
  modport sink(input valid, command, rx_byte, output ready);
endinterface

interface crp_out_if;
  logic        valid;
  logic        ready;
  logic [31:0] frequency_a;
  logic [31:0] frequency_b;
  logic [7:0]  radio_mode;
  logic        transmitting;
  logic [15:0] s_meter;
  logic [15:0] set_power;
  logic [15:0] output_power;
  logic        link_up;
  logic [3:0]  line_kind;
  modport source(output valid, frequency_a, frequency_b, radio_mode, transmitting,
                 s_meter, set_power, output_power, link_up, line_kind, input ready);
  modport sink(input valid, frequency_a, frequency_b, radio_mode, transmitting,
               s_meter, set_power, output_power, link_up, line_kind, output ready);
endinterface

interface crp_cfg_if import crp_pkg::*;;
  logic                 valid;
  logic                 ready;
  logic [TIMEOUT_W-1:0] timeout_ticks;
  modport source(output valid, timeout_ticks, input ready);
  modport sink(input valid, timeout_ticks, output ready);
endinterface

FILE: src/crp_line_store.sv
`timescale 1ns / 1ps

module crp_line_store import crp_pkg::*; #(
  parameter int LINE_CAPACITY = 128
) (
  input  logic       clk,
  input  logic       rst_n,
  crp_in_if.sink     in_ch,
  input  logic       take,
  output tok_t       tok,
  output logic       tok_valid,
  output logic [7:0] rd_third,
  output logic [7:0] rd_tx
);

  localparam int POS_W = $clog2(LINE_CAPACITY);
  localparam int DEPTH = LINE_CAPACITY - 1;
  localparam logic [POS_W-1:0] POS_LAST = POS_W'(LINE_CAPACITY - 1);

  logic [7:0]       line_mem [DEPTH];
  logic [7:0]       rd_third_r;
  logic [7:0]       rd_tx_r;

  logic [POS_W-1:0] pos_r;
  logic [7:0]       first_r;
  logic [7:0]       second_r;
  logic [31:0]      dv_r;
  logic             dv_ended_r;
  logic             over16_r;
  logic [26:0]      info_r;
  logic             info_ended_r;

  tok_t             tok_r;
  tok_t             tok_nxt;
  logic             tok_valid_r;

  logic             accept;
  logic             is_finish;
  logic             store;
  logic [7:0]       b;
  logic [3:0]       d;
  logic [35:0]      dv_wide;
  logic [30:0]      info_wide;

  assign in_ch.ready = !tok_valid_r || take;
  assign accept      = in_ch.valid && in_ch.ready;
  assign b           = in_ch.rx_byte;
  assign d           = b[3:0];
  assign is_finish   = (in_ch.command == CMD_BYTE) && (b == CH_SEMI);
  assign store       = (in_ch.command == CMD_BYTE) && (b != CH_SEMI) && (pos_r < POS_LAST);

  assign dv_wide   = ({4'b0, dv_r} << 3) + ({4'b0, dv_r} << 1) + 36'(d);
  assign info_wide = ({4'b0, info_r} << 3) + ({4'b0, info_r} << 1) + 31'(d);

  always_comb begin
    tok_nxt.op            = (in_ch.command == CMD_TICK) ? OP_TICK :
                            (is_finish ? OP_FINISH : OP_BYTE);
    tok_nxt.first         = first_r;
    tok_nxt.second        = second_r;
    tok_nxt.has_two       = pos_r >= POS_W'(2);
    tok_nxt.has_third     = pos_r > POS_W'(POS_THIRD);
    tok_nxt.has_tx_letter = pos_r >= POS_W'(TX_MIN_LEN);
    tok_nxt.digit_value   = dv_r;
    tok_nxt.over16        = over16_r;
    tok_nxt.info_freq     = info_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r        <= '0;
      first_r      <= '0;
      second_r     <= '0;
      dv_r         <= '0;
      dv_ended_r   <= 1'b0;
      over16_r     <= 1'b0;
      info_r       <= '0;
      info_ended_r <= 1'b0;
    end else if (accept) begin
      if (is_finish) begin
        pos_r        <= '0;
        dv_r         <= '0;
        dv_ended_r   <= 1'b0;
        over16_r     <= 1'b0;
        info_r       <= '0;
        info_ended_r <= 1'b0;
      end else if (store) begin
        pos_r <= pos_r + POS_W'(1);
        if (pos_r == POS_W'(0)) begin
          first_r <= b;
        end else if (pos_r == POS_W'(1)) begin
          second_r <= b;
        end else begin
          if (!dv_ended_r) begin
            if (is_digit(b)) begin
              dv_r <= dv_wide[31:0];
              if (|dv_wide[35:16]) over16_r <= 1'b1;
            end else begin
              dv_ended_r <= 1'b1;
            end
          end
          if ((pos_r <= POS_W'(POS_INFO_LAST)) && !info_ended_r) begin
            if (is_digit(b)) info_r <= info_wide[26:0];
            else info_ended_r <= 1'b1;
          end
        end
      end
    end
  end

  // Line buffer: bytes go in at the fill position, the finish reads the fixed taps.
  always_ff @(posedge clk) begin
    if (accept && store) line_mem[pos_r] <= b;
    if (accept && is_finish) begin
      rd_third_r <= line_mem[POS_W'(POS_THIRD)];
      rd_tx_r    <= line_mem[POS_W'(POS_TX)];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tok_valid_r <= 1'b0;
    end else if (accept) begin
      tok_valid_r <= 1'b1;
    end else if (take) begin
      tok_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) tok_r <= tok_nxt;
  end

  assign tok       = tok_r;
  assign tok_valid = tok_valid_r;
  assign rd_third  = rd_third_r;
  assign rd_tx     = rd_tx_r;

endmodule

FILE: src/crp_status.sv
`timescale 1ns / 1ps

module crp_status import crp_pkg::*; (
  input  logic       clk,
  input  logic       rst_n,
  input  tok_t       tok,
  input  logic       tok_valid,
  input  logic [7:0] rd_third,
  input  logic [7:0] rd_tx,
  output logic       take,
  crp_out_if.source  out_ch,
  crp_cfg_if.sink    cfg_ch
);

  logic [TMO3_W-1:0] tmo3_r;

  logic [31:0] freq_a_r, freq_a_nxt;
  logic [31:0] freq_b_r, freq_b_nxt;
  logic [7:0]  mode_r, mode_nxt;
  logic        tx_r, tx_nxt;
  logic [15:0] meter_r, meter_nxt;
  logic [15:0] set_pwr_r, set_pwr_nxt;
  logic [15:0] out_pwr_r, out_pwr_nxt;
  logic        link_r, link_nxt;
  logic [31:0] idle_r, idle_nxt;
  kind_t       kind_r, kind_nxt;
  logic        out_valid_r;

  logic [7:0]  third;
  logic [15:0] sat16;

  assign take  = tok_valid && (!out_valid_r || out_ch.ready);
  assign third = tok.has_third ? rd_third : 8'h00;
  assign sat16 = tok.over16 ? 16'hFFFF : tok.digit_value[15:0];

  always_comb begin
    freq_a_nxt  = freq_a_r;
    freq_b_nxt  = freq_b_r;
    mode_nxt    = mode_r;
    tx_nxt      = tx_r;
    meter_nxt   = meter_r;
    set_pwr_nxt = set_pwr_r;
    out_pwr_nxt = out_pwr_r;
    link_nxt    = link_r;
    idle_nxt    = idle_r;
    kind_nxt    = KIND_NONE;
    unique case (tok.op)
      OP_TICK: begin
        if (idle_r != '1) idle_nxt = idle_r + 32'd1;
      end
      OP_FINISH: begin
        kind_nxt = KIND_OTHER;
        if (tok.has_two) begin
          idle_nxt = '0;
          unique case ({tok.first, tok.second})
            LN_FA: begin
              freq_a_nxt = tok.digit_value;
              kind_nxt   = KIND_FA;
            end
            LN_FB: begin
              freq_b_nxt = tok.digit_value;
              kind_nxt   = KIND_FB;
            end
            LN_MD: begin
              mode_nxt = map_mode(third);
              kind_nxt = KIND_MD;
            end
            LN_TX: begin
              tx_nxt   = (third == CH_ONE) || (third == CH_TWO);
              kind_nxt = KIND_TX;
            end
            LN_SM: begin
              meter_nxt = sat16;
              kind_nxt  = KIND_SM;
            end
            LN_PC: begin
              set_pwr_nxt = sat16;
              kind_nxt    = KIND_PC;
            end
            LN_PO: begin
              out_pwr_nxt = sat16;
              kind_nxt    = KIND_PO;
            end
            LN_IF: begin
              freq_a_nxt = {5'b0, tok.info_freq};
              if (tok.has_tx_letter) tx_nxt = (rd_tx == CH_ONE);
              link_nxt = 1'b1;
              kind_nxt = KIND_IF;
            end
            LN_OM: begin
              link_nxt = 1'b1;
              kind_nxt = KIND_OM;
            end
            default: ;
          endcase
        end
      end
      OP_BYTE: ;
      default: ;
    endcase
    // drop the link once idle exceeds three timeouts
    if (idle_nxt > 32'(tmo3_r)) link_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      freq_a_r  <= '0;
      freq_b_r  <= '0;
      mode_r    <= '0;
      tx_r      <= 1'b0;
      meter_r   <= '0;
      set_pwr_r <= '0;
      out_pwr_r <= '0;
      link_r    <= 1'b0;
      idle_r    <= '0;
      kind_r    <= KIND_NONE;
    end else if (take) begin
      freq_a_r  <= freq_a_nxt;
      freq_b_r  <= freq_b_nxt;
      mode_r    <= mode_nxt;
      tx_r      <= tx_nxt;
      meter_r   <= meter_nxt;
      set_pwr_r <= set_pwr_nxt;
      out_pwr_r <= out_pwr_nxt;
      link_r    <= link_nxt;
      idle_r    <= idle_nxt;
      kind_r    <= kind_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (take) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tmo3_r <= TMO3_RESET;
    end else if (cfg_ch.valid) begin
      tmo3_r <= TMO3_W'(cfg_ch.timeout_ticks) + (TMO3_W'(cfg_ch.timeout_ticks) << 1);
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.frequency_a  = freq_a_r;
  assign out_ch.frequency_b  = freq_b_r;
  assign out_ch.radio_mode   = mode_r;
  assign out_ch.transmitting = tx_r;
  assign out_ch.s_meter      = meter_r;
  assign out_ch.set_power    = set_pwr_r;
  assign out_ch.output_power = out_pwr_r;
  assign out_ch.link_up      = link_r;
  assign out_ch.line_kind    = kind_r;

endmodule

FILE: src/radio_cat_response_parser_unit.sv
// An accepted item is registered with its line buffer read, then the status update loads the output register.
// Throughput: one item per cycle unless results stall; the line buffer read and status update overlap across items.
// The output register lets the next item in while a result waits to be taken.
// Reset (rst_n low, synchronous): parser and status record clear, timeout returns to 1000 ticks.
// The line buffer needs no clearing pass: entries are used only below the current line length.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module radio_cat_response_parser_unit import crp_pkg::*; #(
  parameter int LINE_CAPACITY = 128
) (
  input  logic      clk,
  input  logic      rst_n,
  crp_in_if.sink    in_ch,
  crp_out_if.source out_ch,
  crp_cfg_if.sink   cfg_ch
);

  tok_t       tok;
  logic       tok_valid;
  logic       take;
  logic [7:0] rd_third;
  logic [7:0] rd_tx;

  crp_line_store #(
    .LINE_CAPACITY(LINE_CAPACITY)
  ) u_line_store (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_ch    (in_ch),
    .take     (take),
    .tok      (tok),
    .tok_valid(tok_valid),
    .rd_third (rd_third),
    .rd_tx    (rd_tx)
  );

  crp_status u_status (
    .clk      (clk),
    .rst_n    (rst_n),
    .tok      (tok),
    .tok_valid(tok_valid),
    .rd_third (rd_third),
    .rd_tx    (rd_tx),
    .take     (take),
    .out_ch   (out_ch),
    .cfg_ch   (cfg_ch)
  );

  `ASSERT_IMPLIES(a_no_overrun, clk, rst_n, in_ch.ready, !tok_valid || take)
  `ASSERT_NEXT(a_take_loads, clk, rst_n, take, out_ch.valid)
  `ASSERT_IMPLIES(a_if_links, clk, rst_n, out_ch.valid && (out_ch.line_kind == KIND_IF), out_ch.link_up)
  `ASSERT_IMPLIES(a_take_needs_tok, clk, rst_n, take, tok_valid)

endmodule
